/* sv/lsrch_pkg.sv */
// lsrch_pkg: shared widths, codes and types of the line substring search core.
// Used by the channel interfaces, the window cell and the top level.
// No dependencies.
package lsrch_pkg;

  localparam int BYTE_W          = 8;
  localparam int LINE_W          = 32;
  localparam int REG_W           = 64;
  localparam int LEN_W           = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int PATTERN_BYTES   = 16;
  localparam int PATTERN_IDX_W   = 4;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int LINE_BUFFER_DEF = 4096;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [LINE_W-1:0] LINE_FIRST   = 32'd1;
  localparam logic [LINE_W-1:0] LINE_MAX     = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  // Per-cycle control broadcast to every window cell.
  typedef struct packed {
    logic shift;  // advance the window by one byte
    logic clear;  // drop the window contents (line or file ended)
  } cell_ctrl_t;

endpackage

/* sv/lsrch_in_if.sv */
// lsrch_in_if: input byte channel (valid/ready) of the line search core.
// Depends on lsrch_pkg.
interface lsrch_in_if;
  logic                          valid;
  logic                          ready;
  logic [lsrch_pkg::BYTE_W-1:0]  data_byte;
  logic                          end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

/* sv/lsrch_out_if.sv */
// lsrch_out_if: result channel (valid/ready) carrying matched line numbers.
// Depends on lsrch_pkg.
interface lsrch_out_if;
  logic                          valid;
  logic                          ready;
  logic [lsrch_pkg::LINE_W-1:0]  matched_line;

  modport source (output valid, output matched_line, input ready);
  modport sink   (input valid, input matched_line, output ready);
endinterface

/* sv/line_substring_search_core.sv */
// line_substring_search_core: fixed-string search inside newline-delimited lines.
// Depends on lsrch_pkg, lsrch_in_if, lsrch_out_if and lsrch_cell.
//
//   channel   dir  payload                           handshake
//   in_item   in   data_byte[7:0], end_of_file       valid/ready
//   out_item  out  matched_line[31:0]                valid/ready
//   cfg_*     in   cfg_index[1:0], cfg_wdata[63:0]   cfg_we, no back-pressure
//
// One byte per cycle while in_item.ready is high. A byte is examined in the cycle it is accepted;
// the line number of a matching line appears in the output register on the
// next cycle. The compare across the cell row is combinational.
// Synchronous active-low reset clears all control state; window bytes are not reset.
// in_item.ready drops only while the output register holds an item that is not taken.
module line_substring_search_core #(
  parameter int MAX_PATTERN = lsrch_pkg::MAX_PATTERN_DEF,
  parameter int LINE_BUFFER = lsrch_pkg::LINE_BUFFER_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lsrch_in_if.sink                         in_item,
  lsrch_out_if.source                      out_item,
  input  logic                             cfg_we,
  input  logic [lsrch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsrch_pkg::REG_W-1:0]      cfg_wdata
);
  import lsrch_pkg::*;

  localparam int CNT_W = (LINE_BUFFER > 2) ? $clog2(LINE_BUFFER) : 1;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_BUFFER - 1);
  localparam int CAP = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;

  // Configuration registers.
  logic [REG_W-1:0] pat_low_r, pat_high_r;
  logic [LEN_W-1:0] pat_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    pat_low_r  <= cfg_wdata;
        CFG_PATTERN_HIGH:   pat_high_r <= cfg_wdata;
        CFG_PATTERN_LENGTH: pat_len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to what the pattern registers and the cell row can hold.
  logic [LEN_W-1:0] used_len;
  always_comb begin
    used_len = pat_len_r;
    if (used_len > LEN_W'(CAP)) begin
      used_len = LEN_W'(CAP);
    end
  end

  logic [PATTERN_BYTES*BYTE_W-1:0] pat_flat;
  assign pat_flat = {pat_high_r, pat_low_r};

  // Line state.
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              has_match_r, has_match_nxt;
  logic              stopped_r, stopped_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0] out_line_r;

  logic fire, is_nl, at_limit, take, line_end, hit, emit, match_new;
  cell_ctrl_t ctrl;

  assign in_item.ready         = !out_valid_r || out_item.ready;
  assign out_item.valid        = out_valid_r;
  assign out_item.matched_line = out_line_r;

  assign fire     = in_item.valid && in_item.ready;
  assign is_nl    = (in_item.data_byte == NEWLINE_BYTE);
  assign at_limit = (cnt_r >= CNT_LIMIT);
  // Store the byte in the window: not stopped, not a newline, room left in the line buffer.
  assign take     = fire && !stopped_r && !is_nl && !at_limit;
  // A newline ends the line; the last byte of a file ends it unless it overflowed.
  assign line_end = fire && !stopped_r && (is_nl || (in_item.end_of_file && !at_limit));
  assign hit      = has_match_r || (take && match_new);
  assign emit     = line_end && (hit || (used_len == '0));

  assign ctrl.shift = take;
  assign ctrl.clear = line_end || (fire && in_item.end_of_file);

  // Cell row: cell 0 takes the incoming byte, each cell hands its byte onward.
  logic [BYTE_W-1:0] cell_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_filled;
  logic [MAX_PATTERN-1:0] cell_ok;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [BYTE_W-1:0]        src_byte;
    logic                     src_filled;
    logic [LEN_W-1:0]         pidx;
    logic                     active;
    logic [BYTE_W-1:0]        pat_b;

    if (k == 0) begin : g_head
      assign src_byte   = in_item.data_byte;
      assign src_filled = 1'b1;
    end else begin : g_link
      assign src_byte   = cell_byte[k-1];
      assign src_filled = cell_filled[k-1];
    end

    // Newest byte sits in cell 0 and lines up with the last pattern byte.
    assign active = (int'(used_len) > k);
    assign pidx   = used_len - LEN_W'(k + 1);
    assign pat_b  = pat_flat[pidx[PATTERN_IDX_W-1:0]*BYTE_W +: BYTE_W];

    lsrch_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .in_byte   (src_byte),
      .in_filled (src_filled),
      .pat_byte  (pat_b),
      .active    (active),
      .byte_r    (cell_byte[k]),
      .filled_r  (cell_filled[k]),
      .ok        (cell_ok[k])
    );
  end

  assign match_new = (used_len != '0) && (&cell_ok);

  always_comb begin
    cnt_nxt       = cnt_r;
    line_nxt      = line_r;
    has_match_nxt = has_match_r;
    stopped_nxt   = stopped_r;
    if (take) begin
      cnt_nxt       = cnt_r + CNT_W'(1);
      has_match_nxt = hit;
    end
    if (line_end) begin
      cnt_nxt       = '0;
      has_match_nxt = 1'b0;
      if (line_r != LINE_MAX) begin
        line_nxt = line_r + LINE_W'(1);
      end
    end
    // Overlong line: stop examining bytes until the file ends.
    if (fire && !stopped_r && !is_nl && at_limit) begin
      stopped_nxt = 1'b1;
    end
    if (fire && in_item.end_of_file) begin
      cnt_nxt       = '0;
      has_match_nxt = 1'b0;
      line_nxt      = LINE_FIRST;
      stopped_nxt   = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      line_r      <= LINE_FIRST;
      has_match_r <= 1'b0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      line_r      <= line_nxt;
      has_match_r <= has_match_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the reported line number until taken.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_line_r <= line_r;
    end
  end

endmodule

/* sv/lsrch_cell.sv */
// lsrch_cell: one stage of the byte window; holds one recent byte and a fill bit,
// compares the byte entering it against its aligned pattern byte. Uses lsrch_pkg.
module lsrch_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsrch_pkg::cell_ctrl_t         ctrl,
  input  logic [lsrch_pkg::BYTE_W-1:0]  in_byte,
  input  logic                          in_filled,
  input  logic [lsrch_pkg::BYTE_W-1:0]  pat_byte,
  input  logic                          active,
  output logic [lsrch_pkg::BYTE_W-1:0]  byte_r,
  output logic                          filled_r,
  output logic                          ok
);
  import lsrch_pkg::*;

  // The incoming byte is what this cell holds after the shift.
  assign ok = !active || (in_filled && (in_byte == pat_byte));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
    end else if (ctrl.clear) begin
      filled_r <= 1'b0;
    end else if (ctrl.shift) begin
      filled_r <= in_filled;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= in_byte;
    end
  end

endmodule
